[design/bcle_pkg.sv]
// ----------------------------------------------------------------------------
// bcle_pkg
// shared types and constants of the bounded circular list engine
// ----------------------------------------------------------------------------
package bcle_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned OUT_COUNT_W = 5;
  localparam int unsigned MAX_RESULTS = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_DEL_FRONT = 3'd2,
    OP_DEL_BACK  = 3'd3,
    OP_INS_AFTER = 3'd4,
    OP_DEL_MATCH = 3'd5,
    OP_EDIT      = 3'd6,
    OP_READ_ALL  = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // datapath actions issued by the controller
  typedef enum logic [3:0] {
    A_NONE,
    A_LATCH,
    A_WALK_INIT,
    A_STEP,
    A_INS_FIRST,
    A_INS_NEW,
    A_INS_TAIL,
    A_DEL_ONLY,
    A_DELF_FIN,
    A_DELB_FIN,
    A_INSA_NEW,
    A_INSA_HIT,
    A_DELM_FIN,
    A_EDIT_FIN
  } act_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_FETCH,
    S_LOOK,
    S_INS_TAIL,
    S_INSA_HIT,
    S_RESP
  } state_t;

  typedef struct packed {
    act_t    act;
    logic    load_out;
    logic    emit_elem;
    logic    last;
    status_t st;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic cnt_zero;
    logic cnt_one;
    logic full;
    logic match;
    logic link_tail;
    logic walk_end;
    logic rd_last;
    logic out_free;
  } stat_t;

endpackage

[design/bcle_ifs.sv]
// ----------------------------------------------------------------------------
// bcle item and result channels
// valid/ready channels carrying list operations and their results
// ----------------------------------------------------------------------------
interface bcle_item_if
  import bcle_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic signed [VALUE_W-1:0] key_value;
  logic signed [VALUE_W-1:0] new_value;

  modport source (output valid, output op, output key_value, output new_value, input ready);
  modport sink   (input valid, input op, input key_value, input new_value, output ready);
endinterface

interface bcle_res_if
  import bcle_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] element;
  logic [OUT_COUNT_W-1:0]    element_count;
  logic                      last;

  modport source (output valid, output status, output element, output element_count,
                  output last, input ready);
  modport sink   (input valid, input status, input element, input element_count,
                  input last, output ready);
endinterface

[design/bounded_circular_list_engine_top.sv]
// ----------------------------------------------------------------------------
// bounded_circular_list_engine_top
// circular linked list of signed 32-bit values with a free-slot map
// ----------------------------------------------------------------------------
// One transaction on in_item carries one list operation; the engine handles
// one transaction at a time. Delete back, insert after, delete match and edit
// walk the linked slots, each visited slot taking one registered read of the
// slot store and one compare. Read all emits one result per element, at most
// 16. Every other operation gives exactly one result with last set. The
// result register frees the engine to take the next transaction while a
// result still waits to be taken. No clearing pass is needed after reset: the
// free map resets to all free and slot contents are only read once written.
module bounded_circular_list_engine_top
  import bcle_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  bcle_item_if.sink   in_item,
  bcle_res_if.source  out_res
);

  // controller / datapath handshake
  cmd_t  cmd;
  stat_t stat;

  bcle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (in_item.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // slot stores, pointers and the result register
  bcle_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_op             (in_item.op),
    .in_key_value      (in_item.key_value),
    .in_new_value      (in_item.new_value),
    .out_valid         (out_res.valid),
    .out_ready         (out_res.ready),
    .out_status        (out_res.status),
    .out_element       (out_res.element),
    .out_element_count (out_res.element_count),
    .out_last          (out_res.last)
  );

endmodule

[design/bcle_ctrl.sv]
// ----------------------------------------------------------------------------
// bcle_ctrl
// operation sequencer: dispatches each transaction and walks the list
// ----------------------------------------------------------------------------
module bcle_ctrl
  import bcle_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DISP;
          st_nxt    = ST_OK;
        end
      end
      S_DISP: begin
        case (stat.op)
          OP_INS_FRONT, OP_INS_BACK: begin
            if (stat.full) begin
              st_nxt    = ST_FULL;
              state_nxt = S_RESP;
            end else if (stat.cnt_zero) begin
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_INS_TAIL;
            end
          end
          OP_DEL_FRONT, OP_DEL_BACK: begin
            if (stat.cnt_zero) begin
              st_nxt    = ST_EMPTY;
              state_nxt = S_RESP;
            end else if (stat.cnt_one) begin
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_FETCH;
            end
          end
          OP_READ_ALL: begin
            if (stat.cnt_zero) begin
              st_nxt    = ST_EMPTY;
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_FETCH;
            end
          end
          default: begin
            if (stat.cnt_zero) begin
              st_nxt    = ST_NOT_FOUND;
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_FETCH;
            end
          end
        endcase
      end
      S_FETCH: state_nxt = S_LOOK;
      S_LOOK: begin
        case (stat.op)
          OP_DEL_FRONT: state_nxt = S_RESP;
          OP_DEL_BACK:  state_nxt = stat.link_tail ? S_RESP : S_FETCH;
          OP_READ_ALL: begin
            if (stat.out_free) begin
              state_nxt = stat.rd_last ? S_IDLE : S_FETCH;
            end
          end
          default: begin
            if (stat.match) begin
              if (stat.op == OP_INS_AFTER) begin
                if (stat.full) begin
                  st_nxt    = ST_FULL;
                  state_nxt = S_RESP;
                end else begin
                  state_nxt = S_INSA_HIT;
                end
              end else begin
                state_nxt = S_RESP;
              end
            end else if (stat.walk_end) begin
              st_nxt    = ST_NOT_FOUND;
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_FETCH;
            end
          end
        endcase
      end
      S_INS_TAIL: state_nxt = S_RESP;
      S_INSA_HIT: state_nxt = S_RESP;
      S_RESP: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd.act       = A_NONE;
    cmd.load_out  = 1'b0;
    cmd.emit_elem = 1'b0;
    cmd.last      = 1'b1;
    cmd.st        = st_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.act = A_LATCH;
        end
      end
      S_DISP: begin
        case (stat.op)
          OP_INS_FRONT, OP_INS_BACK: begin
            if (!stat.full) begin
              cmd.act = stat.cnt_zero ? A_INS_FIRST : A_INS_NEW;
            end
          end
          OP_DEL_FRONT, OP_DEL_BACK: begin
            if (stat.cnt_one) begin
              cmd.act = A_DEL_ONLY;
            end else begin
              cmd.act = A_WALK_INIT;
            end
          end
          default: cmd.act = A_WALK_INIT;
        endcase
      end
      S_LOOK: begin
        case (stat.op)
          OP_DEL_FRONT: cmd.act = A_DELF_FIN;
          OP_DEL_BACK:  cmd.act = stat.link_tail ? A_DELB_FIN : A_STEP;
          OP_READ_ALL: begin
            if (stat.out_free) begin
              cmd.load_out  = 1'b1;
              cmd.emit_elem = 1'b1;
              cmd.last      = stat.rd_last;
              cmd.st        = ST_OK;
              cmd.act       = stat.rd_last ? A_NONE : A_STEP;
            end
          end
          default: begin
            if (stat.match) begin
              case (stat.op)
                OP_INS_AFTER: cmd.act = stat.full ? A_NONE : A_INSA_NEW;
                OP_DEL_MATCH: cmd.act = stat.cnt_one ? A_DEL_ONLY : A_DELM_FIN;
                default:      cmd.act = A_EDIT_FIN;
              endcase
            end else if (!stat.walk_end) begin
              cmd.act = A_STEP;
            end
          end
        endcase
      end
      S_INS_TAIL: cmd.act = A_INS_TAIL;
      S_INSA_HIT: cmd.act = A_INSA_HIT;
      S_RESP:     cmd.load_out = stat.out_free;
      default: ;
    endcase
  end

endmodule

[design/bcle_dpath.sv]
// ----------------------------------------------------------------------------
// bcle_dpath
// slot store, link store, free map, list pointers and result register
// ----------------------------------------------------------------------------
module bcle_dpath
  import bcle_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmd_t                      cmd,
  output stat_t                     stat,
  input  logic [OP_W-1:0]           in_op,
  input  logic signed [VALUE_W-1:0] in_key_value,
  input  logic signed [VALUE_W-1:0] in_new_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [STATUS_W-1:0]       out_status,
  output logic signed [VALUE_W-1:0] out_element,
  output logic [OUT_COUNT_W-1:0]    out_element_count,
  output logic                      out_last
);

  localparam int unsigned SW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned NW = (CW > OUT_COUNT_W) ? CW : OUT_COUNT_W + 1;

  logic signed [VALUE_W-1:0] vmem [CAPACITY];
  logic [SW-1:0]             lmem [CAPACITY];

  op_t                       op_r;
  logic signed [VALUE_W-1:0] key_r, nval_r;
  logic [CAPACITY-1:0]       free_r, free_nxt;
  logic [SW-1:0]             head_r, head_nxt, tail_r, tail_nxt;
  logic [SW-1:0]             cur_r, cur_nxt, prev_r, prev_nxt, new_r, new_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [SW-1:0]             i_r, i_nxt;
  logic signed [VALUE_W-1:0] val_q;
  logic [SW-1:0]             link_q;

  logic                      v_we, l_we;
  logic [SW-1:0]             v_wa, l_wa, l_wd;
  logic signed [VALUE_W-1:0] v_wd;
  logic [SW-1:0]             free_idx;
  logic [CAPACITY-1:0]       one_hot_base;
  logic [NW-1:0]             count_ext, n_emit, i_plus;

  logic                      out_valid_r;
  status_t                   out_status_r;
  logic signed [VALUE_W-1:0] out_element_r;
  logic [OUT_COUNT_W-1:0]    out_count_r;
  logic                      out_last_r;

  assign one_hot_base = {{(CAPACITY-1){1'b0}}, 1'b1};

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if (free_r[k]) begin
        free_idx = SW'(k);
      end
    end
  end

  // slot stores, registered read at the walk cursor
  always_ff @(posedge clk) begin
    if (v_we) begin
      vmem[v_wa] <= v_wd;
    end
    val_q <= vmem[cur_r];
  end

  always_ff @(posedge clk) begin
    if (l_we) begin
      lmem[l_wa] <= l_wd;
    end
    link_q <= lmem[cur_r];
  end

  always_comb begin
    v_we      = 1'b0;
    v_wa      = cur_r;
    v_wd      = nval_r;
    l_we      = 1'b0;
    l_wa      = cur_r;
    l_wd      = head_r;
    free_nxt  = free_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    new_nxt   = new_r;
    count_nxt = count_r;
    i_nxt     = i_r;
    case (cmd.act)
      A_WALK_INIT: begin
        cur_nxt  = head_r;
        prev_nxt = tail_r;
        i_nxt    = '0;
      end
      A_STEP: begin
        prev_nxt = cur_r;
        cur_nxt  = link_q;
        i_nxt    = i_r + 1'b1;
      end
      A_INS_FIRST: begin
        v_we      = 1'b1;
        v_wa      = free_idx;
        v_wd      = key_r;
        l_we      = 1'b1;
        l_wa      = free_idx;
        l_wd      = free_idx;
        free_nxt  = free_r & ~(one_hot_base << free_idx);
        head_nxt  = free_idx;
        tail_nxt  = free_idx;
        count_nxt = CW'(1);
      end
      A_INS_NEW: begin
        v_we      = 1'b1;
        v_wa      = free_idx;
        v_wd      = key_r;
        l_we      = 1'b1;
        l_wa      = free_idx;
        l_wd      = head_r;
        free_nxt  = free_r & ~(one_hot_base << free_idx);
        new_nxt   = free_idx;
        count_nxt = count_r + 1'b1;
        if (op_r == OP_INS_FRONT) begin
          head_nxt = free_idx;
        end
      end
      A_INS_TAIL: begin
        l_we = 1'b1;
        l_wa = tail_r;
        l_wd = new_r;
        if (op_r == OP_INS_BACK) begin
          tail_nxt = new_r;
        end
      end
      A_DEL_ONLY: begin
        free_nxt  = free_r | (one_hot_base << head_r);
        count_nxt = '0;
      end
      A_DELF_FIN: begin
        l_we      = 1'b1;
        l_wa      = tail_r;
        l_wd      = link_q;
        free_nxt  = free_r | (one_hot_base << head_r);
        head_nxt  = link_q;
        count_nxt = count_r - 1'b1;
      end
      A_DELB_FIN: begin
        l_we      = 1'b1;
        l_wa      = cur_r;
        l_wd      = head_r;
        free_nxt  = free_r | (one_hot_base << tail_r);
        tail_nxt  = cur_r;
        count_nxt = count_r - 1'b1;
      end
      A_INSA_NEW: begin
        v_we      = 1'b1;
        v_wa      = free_idx;
        v_wd      = nval_r;
        l_we      = 1'b1;
        l_wa      = free_idx;
        l_wd      = link_q;
        free_nxt  = free_r & ~(one_hot_base << free_idx);
        new_nxt   = free_idx;
        count_nxt = count_r + 1'b1;
      end
      A_INSA_HIT: begin
        l_we = 1'b1;
        l_wa = cur_r;
        l_wd = new_r;
        if (cur_r == tail_r) begin
          tail_nxt = new_r;
        end
      end
      A_DELM_FIN: begin
        l_we      = 1'b1;
        l_wa      = prev_r;
        l_wd      = link_q;
        free_nxt  = free_r | (one_hot_base << cur_r);
        count_nxt = count_r - 1'b1;
        if (cur_r == head_r) begin
          head_nxt = link_q;
        end
        if (cur_r == tail_r) begin
          tail_nxt = prev_r;
        end
      end
      A_EDIT_FIN: begin
        v_we = 1'b1;
        v_wa = cur_r;
        v_wd = nval_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r  <= '1;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      free_r  <= free_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tail_r <= tail_nxt;
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    new_r  <= new_nxt;
    i_r    <= i_nxt;
    if (cmd.act == A_LATCH) begin
      op_r   <= op_t'(in_op);
      key_r  <= in_key_value;
      nval_r <= in_new_value;
    end
  end

  // walk bounds
  assign count_ext = NW'(count_r);
  assign n_emit    = (count_ext > NW'(MAX_RESULTS)) ? NW'(MAX_RESULTS) : count_ext;
  assign i_plus    = NW'(i_r) + 1'b1;

  assign stat.op        = op_r;
  assign stat.cnt_zero  = (count_r == '0);
  assign stat.cnt_one   = (count_r == CW'(1));
  assign stat.full      = (count_r == CW'(CAPACITY));
  assign stat.match     = (val_q == key_r);
  assign stat.link_tail = (link_q == tail_r);
  assign stat.walk_end  = (i_plus == count_ext);
  assign stat.rd_last   = (i_plus == n_emit);
  assign stat.out_free  = !out_valid_r || out_ready;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r  <= cmd.st;
      out_element_r <= cmd.emit_elem ? val_q : '0;
      out_count_r   <= OUT_COUNT_W'(count_nxt);
      out_last_r    <= cmd.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_element       = out_element_r;
  assign out_element_count = out_count_r;
  assign out_last          = out_last_r;

endmodule
